// ===== rtl/led_matrix_scroll_refresh_defines.svh =====
// Assertion macros shared by the LED matrix scan block.
// No dependencies; included by the modules that carry assertions.
`ifndef LED_MATRIX_SCROLL_REFRESH_DEFINES_SVH
`define LED_MATRIX_SCROLL_REFRESH_DEFINES_SVH

// cons must hold in the same cycle as ante
`define LMSR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define LMSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lmsr_pkg.sv =====
// Shared types and constants for the LED matrix scan and scroll block.
// No dependencies.
`default_nettype none

package lmsr_pkg;

   localparam int MATRIX_COUNT_DEF = 8;
   localparam int COLS_PER_MATRIX  = 8;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_SCROLL = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [7:0] BYTE_BLANK   = 8'hFF;
   localparam logic [7:0] BYTE_DARK    = 8'h00;
   localparam logic [7:0] ROW_SEL_BASE = 8'h01;
   localparam logic [2:0] ROW_LAST     = 3'd7;

   typedef enum logic {
      SCAN_IDLE,
      SCAN_READ
   } lmsr_state_type;

   // write side of the frame store
   typedef struct packed {
      logic       we;
      logic       clear;
      logic       fill_ones;
      logic [7:0] data;
   } lmsr_wr_type;

   // item entering the output pipeline
   typedef struct packed {
      logic       load;
      logic       is_sel;
      logic       last;
      logic [7:0] sel_byte;
   } lmsr_slot_type;

endpackage

`default_nettype wire

// ===== rtl/lmsr_store.sv =====
// Frame store: one-port-write, one-port-read synchronous memory with
// per-entry valid bits and a fill value. Depends on lmsr_pkg.
`default_nettype none
`include "led_matrix_scroll_refresh_defines.svh"

module lmsr_store
   import lmsr_pkg::*;
#(
   parameter int MATRIX_COUNT = MATRIX_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lmsr_wr_type           wr,
   input  wire logic [$clog2(MATRIX_COUNT*COLS_PER_MATRIX)-1:0] wr_addr,
   input  wire logic                  rd_en,
   input  wire logic [$clog2(MATRIX_COUNT*COLS_PER_MATRIX)-1:0] rd_addr,
   output logic [7:0]                 rd_byte
);

   localparam int DEPTH = MATRIX_COUNT * COLS_PER_MATRIX;

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       fill_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_vld_ff;
   logic [7:0]       rd_fill_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // capture valid and fill with the read so a later clear cannot alter it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vld_ff  <= valid_ff[rd_addr];
         rd_fill_ff <= fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= BYTE_BLANK;
      end else if (wr.clear) begin
         valid_ff <= '0;
         fill_ff  <= wr.fill_ones ? BYTE_BLANK : BYTE_DARK;
      end else if (wr.we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_byte = rd_vld_ff ? rd_data_ff : rd_fill_ff;

   `LMSR_ASSERT_IMPLY(a_rd_wr_excl, clock, reset, rd_en, !wr.we && !wr.clear, "read overlaps write")

endmodule

`default_nettype wire

// ===== rtl/lmsr_scan.sv =====
// Command sequencer: decodes items, keeps scan row and scroll head,
// and walks the store addresses of a refresh. Depends on lmsr_pkg.
`default_nettype none
`include "led_matrix_scroll_refresh_defines.svh"

module lmsr_scan
   import lmsr_pkg::*;
#(
   parameter int MATRIX_COUNT = MATRIX_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_command,
   input  wire logic [7:0]            req_column_value,
   input  wire logic                  req_fill_ones,
   input  wire logic                  slot_free,
   output lmsr_slot_type              slot,
   output lmsr_wr_type                wr,
   output logic [$clog2(MATRIX_COUNT*COLS_PER_MATRIX)-1:0] wr_addr,
   output logic                       rd_en,
   output logic [$clog2(MATRIX_COUNT*COLS_PER_MATRIX)-1:0] rd_addr
);

   localparam int DEPTH = MATRIX_COUNT * COLS_PER_MATRIX;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (MATRIX_COUNT > 1) ? $clog2(MATRIX_COUNT) : 1;
   localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
   localparam logic [CW-1:0] LAST_M  = CW'(MATRIX_COUNT - 1);

   lmsr_state_type state_ff, state_in;
   logic [2:0]     row_ff, row_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [CW-1:0]  m_ff, m_in;

   logic          accept;
   logic          tick_acc;
   logic [AW:0]   start_sum, step_sum, head_sum;
   logic [AW-1:0] start_addr, step_addr, head_next;

   assign accept   = req_valid && req_ready;
   assign tick_acc = accept && (req_command == CMD_TICK);

   // physical = logical + head, wrapped at the store depth
   assign start_sum  = {1'b0, head_ff} + (AW+1)'(row_ff);
   assign start_addr = (start_sum >= DEPTH_W) ? AW'(start_sum - DEPTH_W) : AW'(start_sum);
   assign step_sum   = {1'b0, addr_ff} + (AW+1)'(COLS_PER_MATRIX);
   assign step_addr  = (step_sum >= DEPTH_W) ? AW'(step_sum - DEPTH_W) : AW'(step_sum);
   assign head_sum   = {1'b0, head_ff} + (AW+1)'(1);
   assign head_next  = (head_sum >= DEPTH_W) ? '0 : AW'(head_sum);

   assign wr_addr = head_ff;
   assign rd_addr = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         row_ff   <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      m_ff    <= m_in;
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      head_in   = head_ff;
      addr_in   = addr_ff;
      m_in      = m_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      slot      = '0;
      wr        = '0;
      wr.data   = ~req_column_value;
      case (state_ff)
         SCAN_IDLE: begin
            req_ready = slot_free;
            if (accept) begin
               case (req_command)
                  CMD_TICK: begin
                     slot.load     = 1'b1;
                     slot.is_sel   = 1'b1;
                     slot.sel_byte = ROW_SEL_BASE << row_ff;
                     row_in        = (row_ff == ROW_LAST) ? '0 : row_ff + 3'd1;
                     addr_in       = start_addr;
                     m_in          = '0;
                     state_in      = SCAN_READ;
                  end
                  CMD_SCROLL: begin
                     // oldest column slot becomes the new last column
                     wr.we   = 1'b1;
                     head_in = head_next;
                  end
                  CMD_CLEAR: begin
                     wr.clear     = 1'b1;
                     wr.fill_ones = req_fill_ones;
                  end
                  default: begin
                  end
               endcase
            end
         end
         SCAN_READ: begin
            if (slot_free) begin
               rd_en     = 1'b1;
               slot.load = 1'b1;
               slot.last = (m_ff == LAST_M);
               addr_in   = step_addr;
               m_in      = m_ff + CW'(1);
               if (m_ff == LAST_M) begin
                  state_in = SCAN_IDLE;
               end
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase
   end

   `LMSR_ASSERT_IMPLY(a_m_bound, clock, reset, state_ff == SCAN_READ, m_ff <= LAST_M, "matrix count overrun")
   `LMSR_ASSERT_NEXT(a_row_hold, clock, reset, !tick_acc, $stable(row_ff), "row moved without tick")

endmodule

`default_nettype wire

// ===== rtl/lmsr_out.sv =====
// Output pipeline: read-data stage followed by the result register,
// full rate while rsp_ready does not stall it. Depends on lmsr_pkg.
`default_nettype none
`include "led_matrix_scroll_refresh_defines.svh"

module lmsr_out
   import lmsr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lmsr_slot_type slot,
   input  wire logic [7:0]    rd_byte,
   output logic               slot_free,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_serial_byte,
   output logic               rsp_latch_now
);

   logic       s1_valid_ff;
   logic       s1_sel_ff;
   logic       s1_last_ff;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_latch_ff;
   logic       out_free;
   logic       s1_move;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign slot_free = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (slot.load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot.load) begin
         s1_sel_ff  <= slot.is_sel;
         s1_last_ff <= slot.last;
         s1_byte_ff <= slot.sel_byte;
      end
      if (s1_move) begin
         rsp_byte_ff  <= s1_sel_ff ? s1_byte_ff : rd_byte;
         rsp_latch_ff <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_serial_byte = rsp_byte_ff;
   assign rsp_latch_now   = rsp_latch_ff;

   `LMSR_ASSERT_IMPLY(a_load_free, clock, reset, slot.load, slot_free, "item loaded into busy stage")

endmodule

`default_nettype wire

// ===== rtl/led_matrix_scroll_refresh.sv =====
// Top level of the LED matrix column store with row-scan refresh.
// Depends on lmsr_pkg, lmsr_scan, lmsr_store and lmsr_out.
//
//   channel  ports               carries
//   req      req_valid/ready     command, column_value, fill_ones
//   rsp      rsp_valid/ready     serial_byte, latch_now
//
// A refresh tick yields 1 + MATRIX_COUNT bytes (9 by default): one row
// select byte, then one byte per store read, the memory's single read
// port giving one byte a cycle while the output pipeline is not stalled.
// After reset the store reads blank (0xFF) at once; there is no sweep.
// rsp_ready low holds the output pipeline and the read walk in place;
// req_ready stays low while a refresh is still reading.
`default_nettype none

module led_matrix_scroll_refresh
   import lmsr_pkg::*;
#(
   parameter int MATRIX_COUNT = MATRIX_COUNT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_column_value,
   input  wire logic       req_fill_ones,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_serial_byte,
   output logic            rsp_latch_now
);

   localparam int AW = $clog2(MATRIX_COUNT * COLS_PER_MATRIX);

   lmsr_slot_type slot;
   lmsr_wr_type   wr;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [7:0]    rd_byte;
   logic          slot_free;

   lmsr_scan #(
      .MATRIX_COUNT(MATRIX_COUNT)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_column_value (req_column_value),
      .req_fill_ones    (req_fill_ones),
      .slot_free        (slot_free),
      .slot             (slot),
      .wr               (wr),
      .wr_addr          (wr_addr),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr)
   );

   lmsr_store #(
      .MATRIX_COUNT(MATRIX_COUNT)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_byte (rd_byte)
   );

   lmsr_out u_out (
      .clock           (clock),
      .reset           (reset),
      .slot            (slot),
      .rd_byte         (rd_byte),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_byte (rsp_serial_byte),
      .rsp_latch_now   (rsp_latch_now)
   );

endmodule

`default_nettype wire
